### design/vtfe_pkg.sv
// ----------------------------------------------------------------------------
// vtfe_pkg
// Types, constants and lookup functions shared by the text field extractor.
// ----------------------------------------------------------------------------
package vtfe_pkg;

  localparam int LINE_BYTES  = 32;
  localparam int BLOCK_LIMIT = 3;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // result status codes
  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [1:0] ST_UNMATCHED = 2'd2;

  // wanted label codes
  localparam logic [1:0] FLD_SOC = 2'd0;
  localparam logic [1:0] FLD_V   = 2'd1;
  localparam logic [1:0] FLD_P   = 2'd2;
  localparam logic [1:0] FLD_I   = 2'd3;

  // register index
  localparam logic REG_WANTED_FIELD = 1'b0;

  localparam logic [31:0] SAT_MAG = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value;
  } out_item_t;

  function automatic logic [7:0] label_char(logic [1:0] fld, logic [1:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case (fld)
      FLD_SOC: begin
        case (idx)
          2'd0:    c = "S";
          2'd1:    c = "O";
          2'd2:    c = "C";
          default: c = 8'h00;
        endcase
      end
      FLD_V:   c = (idx == 2'd0) ? "V" : 8'h00;
      FLD_P:   c = (idx == 2'd0) ? "P" : 8'h00;
      FLD_I:   c = (idx == 2'd0) ? "I" : 8'h00;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] label_len(logic [1:0] fld);
    logic [1:0] n;
    case (fld)
      FLD_SOC: n = 2'd3;
      default: n = 2'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] cks_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = "C";
      3'd1:    c = "h";
      3'd2:    c = "e";
      3'd3:    c = "c";
      3'd4:    c = "k";
      3'd5:    c = "s";
      3'd6:    c = "u";
      3'd7:    c = "m";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### design/ve_text_field_extractor_unit.sv
// ----------------------------------------------------------------------------
// ve_text_field_extractor_unit
// Scans a tab-separated label/value byte stream for one wanted label and
// returns its parsed decimal value, saturated to 32 bits signed.
// ----------------------------------------------------------------------------
// result: the byte that ends it is registered into the output register, or into the skid slot if that is held
// throughput: one request per cycle while in_stall is low; each byte is parsed in a single pass
// two result slots (output register plus skid); in_stall rises only when both hold
// reset (synchronous, rst_n low): search idle, line state cleared, wanted_field 0
module ve_text_field_extractor_unit
  import vtfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [2:0] TK_BEFORE_LABEL = 3'd0;
  localparam logic [2:0] TK_LABEL        = 3'd1;
  localparam logic [2:0] TK_BEFORE_VALUE = 3'd2;
  localparam logic [2:0] TK_VALUE        = 3'd3;
  localparam logic [2:0] TK_DONE         = 3'd4;

  localparam logic [1:0] VP_BLANKS = 2'd0;
  localparam logic [1:0] VP_SIGN   = 2'd1;
  localparam logic [1:0] VP_DIGITS = 2'd2;
  localparam logic [1:0] VP_BAD    = 2'd3;

  localparam logic [5:0] LINE_CAP  = 6'(LINE_BYTES - 1);
  localparam logic [1:0] BLK_LIMIT = 2'(BLOCK_LIMIT);

  logic [1:0]  wanted_r;
  logic        searching_r,   searching_nxt;
  logic [1:0]  blocks_r,      blocks_nxt;
  logic [5:0]  line_len_r,    line_len_nxt;
  logic        text_ended_r,  text_ended_nxt;
  logic        cks_armed_r,   cks_armed_nxt;
  logic        cks_ok_r,      cks_ok_nxt;
  logic [2:0]  token_r,       token_nxt;
  logic        label_ok_r,    label_ok_nxt;
  logic [3:0]  label_len_r,   label_len_nxt;
  logic [31:0] acc_r,         acc_nxt;
  logic        neg_r,         neg_nxt;
  logic [1:0]  vphase_r,      vphase_nxt;

  logic        out_valid_r;
  out_item_t   out_data_r;
  logic        skid_valid_r;
  out_item_t   skid_data_r;

  logic        in_accept;
  logic        out_take;
  logic        res_valid;
  out_item_t   res_item;

  logic [7:0]  b;
  logic        is_tab;
  logic        is_digit;
  logic [3:0]  digit;
  logic        restart;
  logic [35:0] acc_ext;
  logic [35:0] acc_mul;
  logic [31:0] final_val;

  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign in_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign b        = in_data.rx_byte;
  assign is_tab   = (b == CH_TAB);
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign digit    = 4'(b - CH_ZERO);

  // acc * 10 + digit, wide enough to see the overflow
  assign acc_ext = {4'b0, acc_r};
  assign acc_mul = (acc_ext << 3) + (acc_ext << 1) + {32'b0, digit};

  assign final_val = neg_r ? (32'd0 - acc_r) : ((acc_r > POS_MAX) ? POS_MAX : acc_r);

  always_comb begin
    searching_nxt  = searching_r;
    blocks_nxt     = blocks_r;
    line_len_nxt   = line_len_r;
    text_ended_nxt = text_ended_r;
    cks_armed_nxt  = cks_armed_r;
    cks_ok_nxt     = cks_ok_r;
    token_nxt      = token_r;
    label_ok_nxt   = label_ok_r;
    label_len_nxt  = label_len_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    vphase_nxt     = vphase_r;
    restart        = 1'b0;
    res_valid      = 1'b0;
    res_item       = '0;

    if (in_accept) begin
      if (in_data.req_type) begin
        searching_nxt = 1'b1;
        blocks_nxt    = 2'd0;
        cks_armed_nxt = 1'b0;
        restart       = 1'b1;
      end else if (searching_r) begin
        if (b == CH_LF) begin
          restart = 1'b1;
        end else if (b == CH_CR) begin
          if (!text_ended_r) begin
            text_ended_nxt = 1'b1;
            if (token_r != TK_BEFORE_LABEL && label_ok_r &&
                label_len_r == {2'b0, label_len(wanted_r)}) begin
              searching_nxt = 1'b0;
              res_valid     = 1'b1;
              if (vphase_r == VP_DIGITS) begin
                res_item.status = ST_FOUND;
                res_item.value  = final_val;
              end else begin
                res_item.status = ST_NO_DIGITS;
              end
            end
          end
        end else if (cks_armed_r) begin
          // first byte after the Checksum label that is not a tab, CR or LF closes the block
          if (!is_tab) begin
            cks_armed_nxt = 1'b0;
            restart       = 1'b1;
            blocks_nxt    = blocks_r + 2'd1;
            if (blocks_nxt >= BLK_LIMIT) begin
              searching_nxt   = 1'b0;
              res_valid       = 1'b1;
              res_item.status = ST_UNMATCHED;
            end
          end
        end else if (!text_ended_r && line_len_r < LINE_CAP) begin
          line_len_nxt = line_len_r + 6'd1;
          if (line_len_r < 6'd8 && b != cks_char(line_len_r[2:0])) begin
            cks_ok_nxt = 1'b0;
          end
          if (line_len_nxt == 6'd8 && cks_ok_nxt) begin
            cks_armed_nxt = 1'b1;
          end

          case (token_r)
            TK_BEFORE_LABEL, TK_LABEL: begin
              if (is_tab) begin
                if (token_r == TK_LABEL) begin
                  token_nxt = TK_BEFORE_VALUE;
                end
              end else begin
                token_nxt = TK_LABEL;
                if (label_len_r < {2'b0, label_len(wanted_r)}) begin
                  if (b != label_char(wanted_r, label_len_r[1:0])) begin
                    label_ok_nxt = 1'b0;
                  end
                end else begin
                  label_ok_nxt = 1'b0;
                end
                if (label_len_r != 4'hF) begin
                  label_len_nxt = label_len_r + 4'd1;
                end
              end
            end
            TK_BEFORE_VALUE, TK_VALUE: begin
              if (is_tab) begin
                if (token_r == TK_VALUE) begin
                  token_nxt = TK_DONE;
                end
              end else begin
                token_nxt = TK_VALUE;
                case (vphase_r)
                  VP_BLANKS: begin
                    if (b == CH_SPACE || b == CH_VT || b == CH_FF) begin
                      vphase_nxt = VP_BLANKS;
                    end else if (b == CH_PLUS || b == CH_MINUS) begin
                      neg_nxt    = (b == CH_MINUS);
                      vphase_nxt = VP_SIGN;
                    end else if (is_digit) begin
                      acc_nxt    = {28'b0, digit};
                      vphase_nxt = VP_DIGITS;
                    end else begin
                      vphase_nxt = VP_BAD;
                      token_nxt  = TK_DONE;
                    end
                  end
                  VP_SIGN: begin
                    if (is_digit) begin
                      acc_nxt    = {28'b0, digit};
                      vphase_nxt = VP_DIGITS;
                    end else begin
                      vphase_nxt = VP_BAD;
                      token_nxt  = TK_DONE;
                    end
                  end
                  VP_DIGITS: begin
                    if (is_digit) begin
                      acc_nxt = (acc_mul > {4'b0, SAT_MAG}) ? SAT_MAG : acc_mul[31:0];
                    end else begin
                      token_nxt = TK_DONE;
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
            default: begin
            end
          endcase
        end
      end
    end

    if (restart) begin
      line_len_nxt   = 6'd0;
      text_ended_nxt = 1'b0;
      cks_ok_nxt     = 1'b1;
      token_nxt      = TK_BEFORE_LABEL;
      label_ok_nxt   = 1'b1;
      label_len_nxt  = 4'd0;
      acc_nxt        = 32'd0;
      neg_nxt        = 1'b0;
      vphase_nxt     = VP_BLANKS;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      searching_r  <= 1'b0;
      blocks_r     <= 2'd0;
      line_len_r   <= 6'd0;
      text_ended_r <= 1'b0;
      cks_armed_r  <= 1'b0;
      cks_ok_r     <= 1'b1;
      token_r      <= TK_BEFORE_LABEL;
      label_ok_r   <= 1'b1;
      label_len_r  <= 4'd0;
      acc_r        <= 32'd0;
      neg_r        <= 1'b0;
      vphase_r     <= VP_BLANKS;
    end else begin
      searching_r  <= searching_nxt;
      blocks_r     <= blocks_nxt;
      line_len_r   <= line_len_nxt;
      text_ended_r <= text_ended_nxt;
      cks_armed_r  <= cks_armed_nxt;
      cks_ok_r     <= cks_ok_nxt;
      token_r      <= token_nxt;
      label_ok_r   <= label_ok_nxt;
      label_len_r  <= label_len_nxt;
      acc_r        <= acc_nxt;
      neg_r        <= neg_nxt;
      vphase_r     <= vphase_nxt;
    end
  end

  // output register with one skid slot behind it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (res_valid) begin
        out_data_r <= res_item;
      end
    end else if (res_valid) begin
      skid_data_r <= res_item;
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wanted_r <= FLD_SOC;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_WANTED_FIELD) begin
      wanted_r <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WANTED_FIELD) ? {30'b0, wanted_r} : '0;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a result while output register is empty");

  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |=> !searching_r)
    else $error("search still running after a result");

  a_result_needs_search: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> searching_r && in_accept && !in_data.req_type)
    else $error("result raised outside an active search");

  a_value_zero_unless_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_FOUND |-> out_data_r.value == 32'sd0)
    else $error("nonzero value on a result without a found value");

endmodule
